// File: rtl/lmps_pkg.sv
package lmps_pkg;

  localparam int STORE_DEPTH_DEF = 256;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 8;
  localparam int WORD_W     = 32;
  localparam int ROW_W      = 5;
  localparam int ROWS       = 5;
  localparam int ROW_SEL_W  = 3;
  localparam int DWELL_W    = 16;
  localparam int REP_W      = 8;
  localparam int PIU_W      = 9;
  localparam int FRAMES_W   = 15;
  localparam int SPEED_LSB  = 25;
  localparam int SPEED_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [ROW_SEL_W-1:0] LAST_ROW = ROW_SEL_W'(ROWS - 1);
  localparam logic [ROW_W-1:0]     ROWS_OFF = '1;

  localparam logic [DWELL_W-1:0] DWELL_RST = 16'd1000;
  localparam logic [REP_W-1:0]   REP_RST   = 8'd10;
  localparam logic [PIU_W-1:0]   PIU_RST   = 9'd1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DWELL   = 2'd0,
    CFG_REPEAT  = 2'd1,
    CFG_PATTERNS = 2'd2
  } cfg_idx_t;

endpackage

// File: rtl/lmps_if.sv
interface lmps_req_if;
  logic                          valid;
  logic                          ready;
  logic [lmps_pkg::OP_W-1:0]     op;
  logic [lmps_pkg::IDX_W-1:0]    load_addr;
  logic [lmps_pkg::WORD_W-1:0]   load_word;

  modport source (output valid, op, load_addr, load_word, input ready);
  modport sink   (input valid, op, load_addr, load_word, output ready);
endinterface

interface lmps_res_if;
  logic                          valid;
  logic                          ready;
  logic [lmps_pkg::ROW_W-1:0]    column_bits;
  logic [lmps_pkg::ROW_W-1:0]    row_enable_n;
  logic [lmps_pkg::IDX_W-1:0]    shown_index;

  modport source (output valid, column_bits, row_enable_n, shown_index, input ready);
  modport sink   (input valid, column_bits, row_enable_n, shown_index, output ready);
endinterface

interface lmps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lmps_pkg::CFG_IDX_W-1:0]   index;
  logic [lmps_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/led_matrix_pattern_scanner.sv
// A request's result is registered in stage 1 and then in the output register.
// Throughput: one request per cycle unless the output stalls; the pattern
// store has one write and one registered read port, and a load is
// forwarded to a same-cycle read.
// Reset (rst_n low, synchronous): scan idle, pattern 0, registers at
// their defaults. The pattern store is not cleared.
module led_matrix_pattern_scanner #(
  parameter int STORE_DEPTH = lmps_pkg::STORE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  lmps_req_if.sink      in_chan,
  lmps_res_if.source    out_chan,
  lmps_cfg_if.sink      cfg_chan
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int XW = (AW > lmps_pkg::IDX_W) ? AW : lmps_pkg::IDX_W;
  localparam logic [XW:0] DEPTH_X = (XW + 1)'(STORE_DEPTH);

  // configuration
  logic [lmps_pkg::DWELL_W-1:0] dwell_ticks_r;
  logic [lmps_pkg::REP_W-1:0]   repeat_base_r;
  logic [lmps_pkg::PIU_W-1:0]   patterns_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_ticks_r <= lmps_pkg::DWELL_RST;
      repeat_base_r <= lmps_pkg::REP_RST;
      patterns_r    <= lmps_pkg::PIU_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        lmps_pkg::CFG_DWELL:    dwell_ticks_r <= cfg_chan.data;
        lmps_pkg::CFG_REPEAT:   repeat_base_r <= cfg_chan.data[lmps_pkg::REP_W-1:0];
        lmps_pkg::CFG_PATTERNS: patterns_r    <= cfg_chan.data[lmps_pkg::PIU_W-1:0];
        default: ;
      endcase
    end
  end

  // scan state
  logic                           running_r, running_nxt;
  logic [lmps_pkg::ROW_SEL_W-1:0] row_r, row_nxt;
  logic [lmps_pkg::DWELL_W-1:0]   dwell_r, dwell_nxt;
  logic [lmps_pkg::FRAMES_W-1:0]  frames_r, frames_nxt;
  logic [lmps_pkg::IDX_W-1:0]     cur_r, cur_nxt;
  logic                           reload_r, reload_nxt;

  // pipeline
  logic                           s1_valid_r;
  logic                           s1_running_r;
  logic [lmps_pkg::ROW_SEL_W-1:0] s1_row_r;
  logic [lmps_pkg::IDX_W-1:0]     s1_cur_r;
  logic                           s1_inrange_r;
  logic                           out_valid_r;
  logic [lmps_pkg::ROW_W-1:0]     out_col_r;
  logic [lmps_pkg::ROW_W-1:0]     out_row_r;
  logic [lmps_pkg::IDX_W-1:0]     out_idx_r;

  logic in_fire, s1_go;
  assign s1_go          = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || s1_go;
  assign in_fire        = in_chan.valid && in_chan.ready;

  // pattern store
  logic [lmps_pkg::WORD_W-1:0] mem [STORE_DEPTH];
  logic [lmps_pkg::WORD_W-1:0] rd_data_r, fwd_word_r, rd_word, reload_word;
  logic                        fwd_hit_r, rd_inrange_r;
  logic [XW-1:0]               wa_x, ra_x;
  logic [AW-1:0]               wa, ra;
  logic                        we, rd_inrange;

  assign wa_x       = XW'(in_chan.load_addr);
  assign ra_x       = XW'(cur_nxt);
  assign wa         = wa_x[AW-1:0];
  assign ra         = ra_x[AW-1:0];
  assign rd_inrange = {1'b0, ra_x} < DEPTH_X;
  assign we         = in_fire && (in_chan.op == lmps_pkg::OP_LOAD) &&
                      ({1'b0, wa_x} < DEPTH_X);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= in_chan.load_word;
    end
    if (rd_inrange) begin
      rd_data_r <= mem[ra];
    end
    rd_inrange_r <= rd_inrange;
    fwd_hit_r    <= we && (wa == ra);
    fwd_word_r   <= in_chan.load_word;
  end

  assign rd_word     = fwd_hit_r ? fwd_word_r : rd_data_r;
  assign reload_word = rd_inrange_r ? rd_word : '0;

  // frame count of a new pattern, from the word read after the change
  logic [lmps_pkg::SPEED_W:0]             speed_p1;
  logic [lmps_pkg::REP_W+lmps_pkg::SPEED_W:0] reload_prod;
  assign speed_p1    = {1'b0, reload_word[lmps_pkg::SPEED_LSB +: lmps_pkg::SPEED_W]} + 1'b1;
  assign reload_prod = repeat_base_r * speed_p1;

  logic [lmps_pkg::DWELL_W:0] dwell_inc;
  logic [lmps_pkg::PIU_W-1:0] next_idx;
  assign dwell_inc = {1'b0, dwell_r} + 1'b1;
  assign next_idx  = {1'b0, cur_r} + 1'b1;

  always_comb begin
    running_nxt = running_r;
    row_nxt     = row_r;
    dwell_nxt   = dwell_r;
    frames_nxt  = frames_r;
    cur_nxt     = cur_r;
    reload_nxt  = 1'b0;
    if (reload_r) begin
      frames_nxt = reload_prod[lmps_pkg::FRAMES_W-1:0];
    end
    if (in_fire) begin
      unique case (in_chan.op)
        lmps_pkg::OP_TICK: begin
          if (running_r) begin
            if (dwell_inc < {1'b0, dwell_ticks_r}) begin
              dwell_nxt = dwell_inc[lmps_pkg::DWELL_W-1:0];
            end else begin
              dwell_nxt = '0;
              if (row_r < lmps_pkg::LAST_ROW) begin
                row_nxt = row_r + 1'b1;
              end else begin
                row_nxt = '0;
                if (frames_nxt <= lmps_pkg::FRAMES_W'(1)) begin
                  if (next_idx >= patterns_r || next_idx[lmps_pkg::IDX_W]) begin
                    cur_nxt = '0;
                  end else begin
                    cur_nxt = next_idx[lmps_pkg::IDX_W-1:0];
                  end
                  reload_nxt = 1'b1;
                end else begin
                  frames_nxt = frames_nxt - 1'b1;
                end
              end
            end
          end
        end
        lmps_pkg::OP_START: begin
          running_nxt = 1'b1;
          cur_nxt     = '0;
          row_nxt     = '0;
          dwell_nxt   = '0;
          frames_nxt  = lmps_pkg::FRAMES_W'(repeat_base_r);
          reload_nxt  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      row_r     <= '0;
      dwell_r   <= '0;
      frames_r  <= '0;
      cur_r     <= '0;
      reload_r  <= 1'b0;
    end else begin
      running_r <= running_nxt;
      row_r     <= row_nxt;
      dwell_r   <= dwell_nxt;
      frames_r  <= frames_nxt;
      cur_r     <= cur_nxt;
      reload_r  <= reload_nxt;
    end
  end

  // stage 1: snapshot of the state after the request, word arrives here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_running_r <= running_nxt;
      s1_row_r     <= row_nxt;
      s1_cur_r     <= cur_nxt;
      s1_inrange_r <= rd_inrange;
    end
  end

  logic [lmps_pkg::WORD_W-1:0] shown_word;
  logic [lmps_pkg::ROW_W-1:0]  col_sel, col_nxt, rowen_nxt;
  assign shown_word = s1_inrange_r ? rd_word : '0;

  always_comb begin
    unique case (s1_row_r)
      3'd0:    col_sel = shown_word[4:0];
      3'd1:    col_sel = shown_word[9:5];
      3'd2:    col_sel = shown_word[14:10];
      3'd3:    col_sel = shown_word[19:15];
      default: col_sel = shown_word[24:20];
    endcase
    if (s1_running_r) begin
      col_nxt = col_sel;
      if (s1_row_r > lmps_pkg::LAST_ROW) begin
        rowen_nxt = ~(lmps_pkg::ROW_W'(1) << lmps_pkg::LAST_ROW);
      end else begin
        rowen_nxt = ~(lmps_pkg::ROW_W'(1) << s1_row_r);
      end
    end else begin
      col_nxt   = '0;
      rowen_nxt = lmps_pkg::ROWS_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_col_r <= col_nxt;
      out_row_r <= rowen_nxt;
      out_idx_r <= s1_cur_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.column_bits  = out_col_r;
  assign out_chan.row_enable_n = out_row_r;
  assign out_chan.shown_index  = out_idx_r;

endmodule

// File: rtl/lmps_checker.sv
module lmps_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lmps_pkg::ROW_W-1:0]   out_column_bits,
  input logic [lmps_pkg::ROW_W-1:0]   out_row_enable_n,
  input logic [lmps_pkg::IDX_W-1:0]   out_shown_index
);

  a_row_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_enable_n == lmps_pkg::ROWS_OFF) || $onehot(~out_row_enable_n))
    else $error("row enable not one-hot or all off");

  a_dark_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_row_enable_n == lmps_pkg::ROWS_OFF) |-> out_column_bits == '0)
    else $error("columns lit while no row is selected");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_column_bits) &&
      $stable(out_row_enable_n) && $stable(out_shown_index))
    else $error("stalled result changed");

  a_no_valid_in_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind led_matrix_pattern_scanner lmps_checker u_lmps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_column_bits  (out_chan.column_bits),
  .out_row_enable_n (out_chan.row_enable_n),
  .out_shown_index  (out_chan.shown_index)
);
